FILE: hw/rtl/temp_scratchpad_freeze_alarm_defines.svh
`ifndef TEMP_SCRATCHPAD_FREEZE_ALARM_DEFINES_SVH
`define TEMP_SCRATCHPAD_FREEZE_ALARM_DEFINES_SVH

// concurrent check, off while reset is held
`define TSFA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check, live during reset too
`define TSFA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/tsfa_pkg.sv
package tsfa_pkg;

  localparam int DataW     = 8;
  localparam int TempW     = 16;
  localparam int BandW     = 15;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;
  localparam int OutDataW  = 24;
  localparam int FifoDepth = 2;

  localparam logic [3:0]              CheckBytePos = 4'd8;
  localparam logic [DataW-1:0]        CrcPoly      = 8'h8C;
  localparam logic signed [TempW-1:0] ThrReset     = 16'sd300;
  localparam logic [BandW-1:0]        BandReset    = 15'd30;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CRC_BAD   = 2'd1,
    ST_NO_SENSOR = 2'd2
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_BAND      = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    status_t                 status;
    logic signed [TempW-1:0] centi;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_req_t;

  // reflected crc-8, one byte, lsb first
  function automatic logic [DataW-1:0] crc8_step(input logic [DataW-1:0] crc_in,
                                                 input logic [DataW-1:0] b_in);
    logic [DataW-1:0] crc;
    logic [DataW-1:0] b;
    logic             fb;
    crc = crc_in;
    b   = b_in;
    for (int k = 0; k < DataW; k++) begin
      fb  = crc[0] ^ b[0];
      crc = crc >> 1;
      if (fb) begin
        crc = crc ^ CrcPoly;
      end
      b = b >> 1;
    end
    return crc;
  endfunction

  // raw 1/16 degc to centidegrees: raw*25/4 toward zero, saturated
  function automatic logic signed [TempW-1:0] to_centi(input logic [2*DataW-1:0] u);
    logic signed [20:0] raw;
    logic signed [20:0] prod;
    logic signed [20:0] adj;
    logic signed [18:0] q;
    logic signed [TempW-1:0] res;
    raw  = {{5{u[15]}}, u};
    prod = (raw <<< 4) + (raw <<< 3) + raw;
    adj  = prod + (prod[20] ? 21'sd3 : 21'sd0);
    q    = adj[20:2];
    if (q > 19'sd32767) begin
      res = 16'sh7FFF;
    end else if (q < -19'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = q[TempW-1:0];
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/tsfa_front.sv
module tsfa_front import tsfa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [DataW-1:0] in_tdata,
  input  logic             in_tuser,
  input  logic             fifo_full,
  output job_req_t         push
);

  logic [3:0]              idx_r, idx_nxt;
  logic [DataW-1:0]        crc_r, crc_nxt;
  logic [DataW-1:0]        low_r, low_nxt;
  logic signed [TempW-1:0] centi_r, centi_nxt;
  logic                    acc;

  assign in_tready = !fifo_full;
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    idx_nxt         = idx_r;
    crc_nxt         = crc_r;
    low_nxt         = low_r;
    centi_nxt       = centi_r;
    push.valid      = 1'b0;
    push.job.status = ST_OK;
    push.job.centi  = '0;
    if (acc) begin
      if (in_tuser) begin
        push.valid      = 1'b1;
        push.job.status = ST_NO_SENSOR;
        idx_nxt         = '0;
        crc_nxt         = '0;
      end else if (idx_r < CheckBytePos) begin
        if (idx_r == 4'd0) begin
          low_nxt = in_tdata;
        end
        if (idx_r == 4'd1) begin
          centi_nxt = to_centi({in_tdata, low_r});
        end
        crc_nxt = crc8_step(crc_r, in_tdata);
        idx_nxt = idx_r + 4'd1;
      end else begin
        push.valid = 1'b1;
        if (in_tdata == crc_r) begin
          push.job.status = ST_OK;
          push.job.centi  = centi_r;
        end else begin
          push.job.status = ST_CRC_BAD;
        end
        idx_nxt = '0;
        crc_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      crc_r <= '0;
    end else begin
      idx_r <= idx_nxt;
      crc_r <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    low_r   <= low_nxt;
    centi_r <= centi_nxt;
  end

endmodule

FILE: hw/rtl/tsfa_fifo.sv
module tsfa_fifo import tsfa_pkg::*; #(
  parameter int DEPTH = FifoDepth
) (
  input  logic     clk,
  input  logic     rst_n,
  input  job_req_t push,
  input  logic     pop,
  output job_req_t head,
  output logic     full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push;

  assign full       = (cnt_r == CW'(DEPTH));
  assign do_push    = push.valid && !full;
  assign head.valid = (cnt_r != '0);
  assign head.job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!do_push && pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.job;
    end
  end

endmodule

FILE: hw/rtl/tsfa_back.sv
module tsfa_back import tsfa_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  job_req_t                head,
  output logic                    pop,
  input  logic signed [TempW-1:0] thr,
  input  logic [BandW-1:0]        band,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OutDataW-1:0]     out_tdata,
  output logic [1:0]              out_tuser
);

  logic                    alarm_r, alarm_nxt;
  logic                    out_valid_r, out_valid_nxt;
  status_t                 status_r;
  logic signed [TempW-1:0] centi_r;
  logic                    flag_r;
  logic                    chg_r;
  logic signed [17:0]      thr_ext;
  logic signed [17:0]      upper;
  logic signed [17:0]      centi_ext;

  assign pop       = head.valid && (!out_valid_r || out_tready);
  assign thr_ext   = {{2{thr[TempW-1]}}, thr};
  assign upper     = thr_ext + $signed({3'b000, band});
  assign centi_ext = {{2{head.job.centi[TempW-1]}}, head.job.centi};

  always_comb begin
    alarm_nxt = alarm_r;
    if (pop && head.job.status == ST_OK) begin
      if (centi_ext <= thr_ext) begin
        alarm_nxt = 1'b1;
      end else if (centi_ext >= upper) begin
        alarm_nxt = 1'b0;
      end
    end
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      alarm_r     <= alarm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status_r <= head.job.status;
      centi_r  <= head.job.centi;
      flag_r   <= alarm_nxt;
      chg_r    <= (alarm_nxt != alarm_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW - TempW - 2){1'b0}}, chg_r, flag_r, centi_r};
  assign out_tuser  = status_r;

endmodule

FILE: hw/rtl/temp_scratchpad_freeze_alarm.sv
// Scratchpad reader with CRC-8 check and freeze alarm. Send the nine scratchpad
// bytes one item each, byte 0 first; in_tuser high marks a bus fault and aborts
// the reading. One input item is taken every cycle while the queue is not full.
// The check byte (or the fault) pushes a result into the queue: the front end
// runs the CRC step of one byte in a cycle, a two-entry queue carries finished
// readings to the back end, and the back end applies the alarm rule once per
// result into the output register. A stalled output holds up the input only
// once the queue is full. Write configuration only while the block is idle.
module temp_scratchpad_freeze_alarm import tsfa_pkg::*; #(
  parameter int FIFO_DEPTH = FifoDepth
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [DataW-1:0]    in_tdata,   // data_byte[7:0]
  input  logic                in_tuser,   // bus_fault
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // temperature_centi[15:0], freeze_alarm, alarm_changed
  output logic [1:0]          out_tuser,  // read_status[1:0]
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  logic signed [TempW-1:0] thr_r;
  logic [BandW-1:0]        band_r;
  job_req_t                push;
  job_req_t                head;
  logic                    fifo_full;
  logic                    pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= ThrReset;
      band_r <= BandReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD: thr_r  <= $signed(cfg_data[TempW-1:0]);
        REG_BAND:      band_r <= cfg_data[BandW-1:0];
        default: ;
      endcase
    end
  end

  tsfa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .fifo_full (fifo_full),
    .push      (push)
  );

  tsfa_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (fifo_full)
  );

  tsfa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .thr        (thr_r),
    .band       (band_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: hw/rtl/tsfa_checker.sv
`include "temp_scratchpad_freeze_alarm_defines.svh"

module tsfa_checker import tsfa_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata,
  input logic [1:0]          out_tuser
);

  logic last_alarm_r;

  // alarm as last delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_alarm_r <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      last_alarm_r <= out_tdata[16];
    end
  end

  `TSFA_ASSERT(a_hold_valid, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "output item dropped while stalled")
  `TSFA_ASSERT(a_hold_data, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser), "output item changed while stalled")
  `TSFA_ASSERT(a_fail_clean, clk, rst_n, out_tvalid && out_tuser != ST_OK |-> out_tdata[15:0] == '0 && !out_tdata[17], "failed reading carries a value or an alarm change")
  `TSFA_ASSERT(a_change_flag, clk, rst_n, out_tvalid |-> (out_tdata[16] != last_alarm_r) == out_tdata[17], "alarm change flag disagrees with alarm history")
  `TSFA_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_tvalid, "output valid right after reset")

endmodule

bind temp_scratchpad_freeze_alarm tsfa_checker u_tsfa_checker (.*);
